### design/pa_list_pkg.sv
// shared codes, widths and control struct for the positional array list
package pa_list_pkg;

  localparam int CAPACITY_DEF = 12;

  localparam int CMD_W    = 2;
  localparam int POS_W    = 4;
  localparam int VAL_W    = 32;
  localparam int STS_W    = 2;
  localparam int OCOUNT_W = 4;

  // command codes
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_COUNT  = 2'd3;

  // result status codes
  localparam logic [STS_W-1:0] STS_OK     = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY  = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL   = 2'd2;
  localparam logic [STS_W-1:0] STS_BADPOS = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic              load;       // capture a result into the output register
    logic              shift_up;   // insert at idx
    logic              shift_down; // remove at idx
    logic              take_data;  // result carries the entry at idx
    logic [POS_W-1:0]  idx;        // 0-based entry index
    logic [STS_W-1:0]  status;
  } ctl_t;

endpackage

### design/pa_list_ctrl.sv
// controller: command decode, checks and output handshake state
module pa_list_ctrl #(
  parameter int CAPACITY = pa_list_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pa_list_pkg::CMD_W-1:0]  cmd,
  input  logic [pa_list_pkg::POS_W-1:0]  position,
  output logic                           out_valid,
  input  logic                           out_ready,
  input  logic [CNT_W-1:0]               count,
  output pa_list_pkg::ctl_t              ctl
);

  localparam int CMP_W = (CNT_W > pa_list_pkg::POS_W + 1) ? CNT_W : pa_list_pkg::POS_W + 1;
  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic             state_r;
  logic             state_nxt;
  logic             fire;
  logic [CMP_W-1:0] p;
  logic [CMP_W-1:0] c;
  logic [pa_list_pkg::STS_W-1:0] sts;

  assign in_ready  = (state_r == S_IDLE) || out_ready;
  assign out_valid = (state_r == S_HOLD);
  assign fire      = in_valid && in_ready;

  assign p = CMP_W'(position);
  assign c = CMP_W'(count);

  always_comb begin
    sts = pa_list_pkg::STS_OK;
    case (cmd)
      pa_list_pkg::CMD_READ, pa_list_pkg::CMD_REMOVE: begin
        if (c == '0) begin
          sts = pa_list_pkg::STS_EMPTY;
        end else if (p == '0 || p > c) begin
          sts = pa_list_pkg::STS_BADPOS;
        end
      end
      pa_list_pkg::CMD_INSERT: begin
        if (c >= CAP_C) begin
          sts = pa_list_pkg::STS_FULL;
        end else if (p == '0 || p > c + CMP_W'(1)) begin
          sts = pa_list_pkg::STS_BADPOS;
        end
      end
      default: sts = pa_list_pkg::STS_OK;
    endcase
  end

  always_comb begin
    ctl.load       = fire;
    ctl.status     = sts;
    ctl.idx        = position - pa_list_pkg::POS_W'(1);
    ctl.shift_up   = fire && (cmd == pa_list_pkg::CMD_INSERT) && (sts == pa_list_pkg::STS_OK);
    ctl.shift_down = fire && (cmd == pa_list_pkg::CMD_REMOVE) && (sts == pa_list_pkg::STS_OK);
    ctl.take_data  = ((cmd == pa_list_pkg::CMD_READ) || (cmd == pa_list_pkg::CMD_REMOVE))
                     && (sts == pa_list_pkg::STS_OK);
  end

  always_comb begin
    state_nxt = state_r;
    if (fire) begin
      state_nxt = S_HOLD;
    end else if (out_ready) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/pa_list_dp.sv
// datapath: row of shifting entry cells, fill count and result register
module pa_list_dp #(
  parameter int CAPACITY = pa_list_pkg::CAPACITY_DEF,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pa_list_pkg::ctl_t                 ctl,
  input  logic [pa_list_pkg::VAL_W-1:0]     value,
  output logic [CNT_W-1:0]                  count,
  output logic [pa_list_pkg::STS_W-1:0]     res_status,
  output logic [pa_list_pkg::VAL_W-1:0]     res_data,
  output logic [pa_list_pkg::OCOUNT_W-1:0]  res_count
);

  localparam int CMP_W = (CNT_W > pa_list_pkg::POS_W + 1) ? CNT_W : pa_list_pkg::POS_W + 1;
  localparam int OC_W  = (CNT_W > pa_list_pkg::OCOUNT_W) ? CNT_W : pa_list_pkg::OCOUNT_W;

  logic [pa_list_pkg::VAL_W-1:0] entry_r [CAPACITY];
  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;
  logic [pa_list_pkg::VAL_W-1:0] rd_val;
  logic [CMP_W-1:0]              idx_c;
  logic [CMP_W-1:0]              cnt_c;
  logic [OC_W-1:0]               cnt_o;

  assign count = count_r;
  assign idx_c = CMP_W'(ctl.idx);
  assign cnt_c = CMP_W'(count_r);

  // select the entry at idx
  always_comb begin
    rd_val = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      if (CMP_W'(j) == idx_c) begin
        rd_val = entry_r[j];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.shift_up) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.shift_down) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // each cell takes its lower neighbor on insert, its upper one on remove
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [pa_list_pkg::VAL_W-1:0] below;
    logic [pa_list_pkg::VAL_W-1:0] above;
    if (j == 0) begin : g_first
      assign below = value;
    end else begin : g_mid_lo
      assign below = entry_r[j-1];
    end
    if (j == CAPACITY - 1) begin : g_last
      assign above = entry_r[j];
    end else begin : g_mid_hi
      assign above = entry_r[j+1];
    end

    always_ff @(posedge clk) begin
      if (ctl.shift_up) begin
        if (CMP_W'(j) == idx_c) begin
          entry_r[j] <= value;
        end else if (CMP_W'(j) > idx_c && CMP_W'(j) <= cnt_c) begin
          entry_r[j] <= below;
        end
      end else if (ctl.shift_down) begin
        if (CMP_W'(j) >= idx_c && CMP_W'(j) + CMP_W'(1) < cnt_c) begin
          entry_r[j] <= above;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign cnt_o = OC_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      res_status <= ctl.status;
      res_data   <= ctl.take_data ? rd_val : '0;
      res_count  <= cnt_o[pa_list_pkg::OCOUNT_W-1:0];
    end
  end

endmodule

### design/positional_array_list_top.sv
// top level of the positional array list: stream ports, controller and datapath
//
// a bounded ordered list of signed 32-bit values, CAPACITY entries deep
// input stream carries one command per transfer: read at a 1-based position,
// insert at a position, remove at a position, or report the count
// every command produces exactly one result transfer on the output stream
// carrying a status code, the value read or removed (zero otherwise) and the
// count after the command
// a command runs in the cycle its transfer completes: all entry cells shift
// in parallel, so the result is in the output register in the next cycle
// throughput is one command per cycle while the receiver takes results, set
// by the single output register, which is refilled in the same cycle it drains
// when the receiver stalls the result register holds and in_tready drops
// until the result transfer completes
// reset (rst_n low, synchronous) empties the list and drops out_tvalid;
// entry storage is not cleared, positions past the count are rejected
// a rejected command (empty, full, bad position) leaves the list unchanged
module positional_array_list_top #(
  parameter int CAPACITY = pa_list_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd[1:0], position[5:2], value[37:6], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // status[1:0], data[33:2], count[37:34], zero pad
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  pa_list_pkg::ctl_t                 ctl;
  logic [CNT_W-1:0]                  count;
  logic [pa_list_pkg::STS_W-1:0]     res_status;
  logic [pa_list_pkg::VAL_W-1:0]     res_data;
  logic [pa_list_pkg::OCOUNT_W-1:0]  res_count;

  // command decode, checks and result handshake
  pa_list_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .cmd       (in_tdata[1:0]),
    .position  (in_tdata[5:2]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .count     (count),
    .ctl       (ctl)
  );

  // entry cells, fill count and result register
  pa_list_dp #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .value      (in_tdata[37:6]),
    .count      (count),
    .res_status (res_status),
    .res_data   (res_data),
    .res_count  (res_count)
  );

  // result packing, lowest field first
  assign out_tdata = {2'b00, res_count, res_data, res_status};

endmodule
